### hdl/ggdc_pkg.sv
// Shared types, widths and constants for the go-to-goal drive controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ggdc_pkg;

    // Default number of CORDIC rotation cells.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Field widths.
    localparam int POS_W   = 16;
    localparam int HEAD_W  = 15;
    localparam int GAIN_W  = 12;
    localparam int SPEED_W = 15;
    localparam int TURN_W  = 15;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Internal datapath widths.
    localparam int DIFF_W = POS_W + 1;       // goal minus position
    localparam int SQ_W   = 2 * POS_W;       // one squared offset
    localparam int D2_W   = SQ_W + 1;        // sum of both squares
    localparam int CW     = 27;              // CORDIC x and y
    localparam int ZW     = 20;              // CORDIC angle, Q.16
    localparam int ATW    = 17;              // arctangent table entry
    localparam int BRG_W  = ZW - 4;          // bearing, Q3.12
    localparam int ERR_W  = BRG_W + 1;       // heading error
    localparam int RAD_W  = D2_W + 1;        // radicand padded to even width
    localparam int ROOT_W = RAD_W / 2;       // integer square root
    localparam int REM_W  = ROOT_W + 3;      // partial remainder
    localparam int PROD_W = GAIN_W + ROOT_W; // gain times distance

    localparam logic signed [ZW-1:0]  PI_Q16      = 20'sd205887;
    localparam logic [D2_W-1:0]       AT_GOAL_D2  = 33'd655;
    localparam logic [ERR_W-1:0]      TURN_THRESH = 17'd819;

    // Arctangent of 2^-i in Q.16 radians, rounded to nearest.
    localparam logic [ATW-1:0] ATAN_Q16 [ATAN_ENTRIES] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024,  17'd512,   17'd256,   17'd128,  17'd64,   17'd32,
        17'd16,    17'd8,     17'd4,     17'd2,    17'd1,    17'd0,
        17'd0,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0
    };

    typedef enum logic [IDX_W-1:0] {
        REG_GOAL_X      = 3'd0,
        REG_GOAL_Y      = 3'd1,
        REG_SPEED_GAIN  = 3'd2,
        REG_SPEED_LIMIT = 3'd3
    } cfg_reg_t;

    // Vector being rotated by the CORDIC cells.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_vec_t;

    // Data that rides along with the CORDIC vector.
    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic [D2_W-1:0]          d2;
    } cordic_tag_t;

    // Working set of the square root cells.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_vec_t;

    // Decision flags that ride along with the square root.
    typedef struct packed {
        logic              at_goal;
        logic              turning;
        logic [TURN_W-1:0] mag;
    } sqrt_tag_t;

endpackage

`default_nettype wire

### hdl/ggdc_cordic_cell.sv
// One CORDIC vectoring cell: rotates the vector toward y = 0 by atan(2^-STAGE).
// Depends on ggdc_pkg for the vector types and the arctangent table.
`default_nettype none

module ggdc_cordic_cell
    import ggdc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        valid_in,
    input  wire cordic_vec_t vec_in,
    input  wire cordic_tag_t tag_in,
    output logic             valid_out,
    output cordic_vec_t      vec_out,
    output cordic_tag_t      tag_out
);

    localparam logic signed [ZW-1:0] ANGLE = signed'({{(ZW-ATW){1'b0}}, ATAN_Q16[STAGE]});

    logic                 valid_reg;
    cordic_vec_t          vec_reg;
    cordic_tag_t          tag_reg;
    cordic_vec_t          vec_next;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb
    begin
        x_in = vec_in.x;
        y_in = vec_in.y;
        xs   = x_in >>> STAGE;
        ys   = y_in >>> STAGE;
        // A y of zero counts as positive.
        if (!y_in[CW-1])
        begin
            vec_next.x = x_in + ys;
            vec_next.y = y_in - xs;
            vec_next.z = vec_in.z + ANGLE;
        end
        else
        begin
            vec_next.x = x_in - ys;
            vec_next.y = y_in + xs;
            vec_next.z = vec_in.z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg <= vec_next;
            tag_reg <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign vec_out   = vec_reg;
    assign tag_out   = tag_reg;

endmodule

`default_nettype wire

### hdl/ggdc_sqrt_cell.sv
// One digit of a restoring integer square root: brings down two radicand bits
// and decides one root bit. Depends on ggdc_pkg for the cell types.
`default_nettype none

module ggdc_sqrt_cell
    import ggdc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire logic      valid_in,
    input  wire sqrt_vec_t vec_in,
    input  wire sqrt_tag_t tag_in,
    output logic           valid_out,
    output sqrt_vec_t      vec_out,
    output sqrt_tag_t      tag_out
);

    logic             valid_reg;
    sqrt_vec_t        vec_reg;
    sqrt_tag_t        tag_reg;
    sqrt_vec_t        vec_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        // The remainder never exceeds twice the root, so its top bits are free.
        rem_sh       = {vec_in.rem[REM_W-3:0], vec_in.rad[RAD_W-1:RAD_W-2]};
        trial        = {1'b0, vec_in.root, 2'b01};
        vec_next.rad = {vec_in.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            vec_next.rem  = rem_sh - trial;
            vec_next.root = {vec_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            vec_next.rem  = rem_sh;
            vec_next.root = {vec_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg <= vec_next;
            tag_reg <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign vec_out   = vec_reg;
    assign tag_out   = tag_reg;

endmodule

`default_nettype wire

### hdl/go_to_goal_drive_controller_top.sv
// Top level of the go-to-goal drive controller: front end, CORDIC and square
// root cell chains, decision and output register. Depends on ggdc_pkg and cells.
`default_nettype none

// The block takes one pose per clock and returns one drive command per pose,
// in order, through three front-end stages, one CORDIC cell per stage, one
// decision stage, seventeen square root cells and the output register. The
// pipeline moves as a whole: it holds only while the output register holds a
// result that the consumer stalls, and otherwise a request is taken in every
// cycle. Goal, gain and speed limit are plain registers; the user must write
// them only while no pose is in flight, and the block itself does not enforce
// this.
module go_to_goal_drive_controller_top
    import ggdc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [POS_W-1:0]   pos_x,
    input  wire logic signed [POS_W-1:0]   pos_y,
    input  wire logic signed [HEAD_W-1:0]  heading,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [SPEED_W-1:0]             linear_speed,
    output logic [TURN_W-1:0]              turn_rate
);

    // Configuration registers.
    logic signed [POS_W-1:0] goal_x_reg;
    logic signed [POS_W-1:0] goal_y_reg;
    logic [GAIN_W-1:0]       speed_gain_reg;
    logic [SPEED_W-1:0]      speed_limit_reg;

    logic advance;
    logic accept;

    // Front end stage 1: offsets to the goal.
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg;
    logic signed [DIFF_W-1:0] s1_dy_reg;
    logic signed [HEAD_W-1:0] s1_hd_reg;
    logic signed [DIFF_W-1:0] s1_dx_next;
    logic signed [DIFF_W-1:0] s1_dy_next;

    // Front end stage 2: squares and the pre-rotated CORDIC vector.
    logic                       s2_valid_reg;
    logic [SQ_W-1:0]            s2_sqx_reg;
    logic [SQ_W-1:0]            s2_sqy_reg;
    logic signed [HEAD_W-1:0]   s2_hd_reg;
    cordic_vec_t                s2_vec_reg;
    logic signed [2*DIFF_W-1:0] sqx_full;
    logic signed [2*DIFF_W-1:0] sqy_full;
    logic signed [CW-1:0]       x_scaled;
    logic signed [CW-1:0]       y_scaled;
    cordic_vec_t                s2_vec_next;

    // Front end stage 3: squared distance, head of the CORDIC chain.
    logic        s3_valid_reg;
    cordic_vec_t s3_vec_reg;
    cordic_tag_t s3_tag_reg;
    cordic_tag_t s3_tag_next;

    logic        cv_valid [CORDIC_STAGES+1];
    cordic_vec_t cv_vec   [CORDIC_STAGES+1];
    cordic_tag_t cv_tag   [CORDIC_STAGES+1];

    // Decision stage: bearing, heading error and the at-goal test.
    logic signed [ZW-1:0]    z_round;
    logic signed [BRG_W-1:0] bearing;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        mag;
    logic                    dq_valid_reg;
    sqrt_vec_t               dq_vec_reg;
    sqrt_tag_t               dq_tag_reg;
    sqrt_vec_t               dq_vec_next;
    sqrt_tag_t               dq_tag_next;

    logic      sv_valid [ROOT_W+1];
    sqrt_vec_t sv_vec   [ROOT_W+1];
    sqrt_tag_t sv_tag   [ROOT_W+1];

    // Output stage.
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-9:0]         scaled;
    logic [SPEED_W-1:0]        lin_next;
    logic [TURN_W-1:0]         turn_next;
    logic                      out_valid_reg;
    logic [SPEED_W-1:0]        linear_speed_reg;
    logic [TURN_W-1:0]         turn_rate_reg;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg      <= -16'sd256;
            goal_y_reg      <= 16'sd256;
            speed_gain_reg  <= 12'd256;
            speed_limit_reg <= 15'd768;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GOAL_X:      goal_x_reg      <= signed'(cfg_data);
                REG_GOAL_Y:      goal_y_reg      <= signed'(cfg_data);
                REG_SPEED_GAIN:  speed_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[SPEED_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Flow control: the whole pipeline holds only behind a stalled result.
    // ---------------------------------------------------------------------
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // ---------------------------------------------------------------------
    // Front end
    // ---------------------------------------------------------------------
    assign s1_dx_next = DIFF_W'(goal_x_reg) - DIFF_W'(pos_x);
    assign s1_dy_next = DIFF_W'(goal_y_reg) - DIFF_W'(pos_y);

    always_comb
    begin
        sqx_full = s1_dx_reg * s1_dx_reg;
        sqy_full = s1_dy_reg * s1_dy_reg;
        x_scaled = CW'(signed'({s1_dx_reg, 8'b0}));
        y_scaled = CW'(signed'({s1_dy_reg, 8'b0}));
        // A vector in the left half plane is turned by pi before rotation.
        if (s1_dx_reg[DIFF_W-1])
        begin
            s2_vec_next.x = -x_scaled;
            s2_vec_next.y = -y_scaled;
            s2_vec_next.z = s1_dy_reg[DIFF_W-1] ? -PI_Q16 : PI_Q16;
        end
        else
        begin
            s2_vec_next.x = x_scaled;
            s2_vec_next.y = y_scaled;
            s2_vec_next.z = '0;
        end
    end

    always_comb
    begin
        s3_tag_next.heading = s2_hd_reg;
        s3_tag_next.d2      = D2_W'(s2_sqx_reg) + D2_W'(s2_sqy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_hd_reg  <= heading;
            s2_sqx_reg <= sqx_full[SQ_W-1:0];
            s2_sqy_reg <= sqy_full[SQ_W-1:0];
            s2_hd_reg  <= s1_hd_reg;
            s2_vec_reg <= s2_vec_next;
            s3_vec_reg <= s2_vec_reg;
            s3_tag_reg <= s3_tag_next;
        end
    end

    // ---------------------------------------------------------------------
    // CORDIC chain
    // ---------------------------------------------------------------------
    assign cv_valid[0] = s3_valid_reg;
    assign cv_vec[0]   = s3_vec_reg;
    assign cv_tag[0]   = s3_tag_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        ggdc_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (cv_valid[g]),
            .vec_in    (cv_vec[g]),
            .tag_in    (cv_tag[g]),
            .valid_out (cv_valid[g+1]),
            .vec_out   (cv_vec[g+1]),
            .tag_out   (cv_tag[g+1])
        );
    end

    // ---------------------------------------------------------------------
    // Decision stage
    // ---------------------------------------------------------------------
    always_comb
    begin
        z_round = cv_vec[CORDIC_STAGES].z + ZW'(8);
        bearing = z_round[ZW-1:4];
        err     = ERR_W'(bearing) - ERR_W'(cv_tag[CORDIC_STAGES].heading);
        mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

        dq_vec_next.rad  = RAD_W'(cv_tag[CORDIC_STAGES].d2);
        dq_vec_next.rem  = '0;
        dq_vec_next.root = '0;

        dq_tag_next.at_goal = (cv_tag[CORDIC_STAGES].d2 <= AT_GOAL_D2);
        dq_tag_next.turning = (mag > TURN_THRESH);
        // The error magnitude stays below 2^15 for any input.
        dq_tag_next.mag     = mag[TURN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            dq_valid_reg <= cv_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dq_vec_reg <= dq_vec_next;
            dq_tag_reg <= dq_tag_next;
        end
    end

    // ---------------------------------------------------------------------
    // Square root chain
    // ---------------------------------------------------------------------
    assign sv_valid[0] = dq_valid_reg;
    assign sv_vec[0]   = dq_vec_reg;
    assign sv_tag[0]   = dq_tag_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        ggdc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (sv_valid[k]),
            .vec_in    (sv_vec[k]),
            .tag_in    (sv_tag[k]),
            .valid_out (sv_valid[k+1]),
            .vec_out   (sv_vec[k+1]),
            .tag_out   (sv_tag[k+1])
        );
    end

    // ---------------------------------------------------------------------
    // Output stage
    // ---------------------------------------------------------------------
    always_comb
    begin
        prod   = PROD_W'(speed_gain_reg) * PROD_W'(sv_vec[ROOT_W].root);
        scaled = prod[PROD_W-1:8];
        if (sv_tag[ROOT_W].at_goal)
        begin
            lin_next  = '0;
            turn_next = '0;
        end
        else if (sv_tag[ROOT_W].turning)
        begin
            lin_next  = '0;
            turn_next = sv_tag[ROOT_W].mag;
        end
        else
        begin
            lin_next  = (scaled > (PROD_W-8)'(speed_limit_reg)) ? speed_limit_reg
                                                                : scaled[SPEED_W-1:0];
            turn_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= sv_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            linear_speed_reg <= lin_next;
            turn_rate_reg    <= turn_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign linear_speed = linear_speed_reg;
    assign turn_rate    = turn_rate_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (linear_speed_reg == '0 || turn_rate_reg == '0))
        else $error("drive and turn commands issued together");

    a_speed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (linear_speed_reg <= speed_limit_reg))
        else $error("linear speed above the configured limit");

    a_turn_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && turn_rate_reg != '0) |-> (ERR_W'(turn_rate_reg) > TURN_THRESH))
        else $error("turn command below the heading threshold");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (sv_valid[ROOT_W] == $past(sv_valid[ROOT_W])))
        else $error("pipeline moved behind a stalled result");

endmodule

`default_nettype wire

### verif/go_to_goal_drive_controller_top_tb.sv
// Testbench for go_to_goal_drive_controller_top: directed poses, then random poses
// under several goal, gain and limit settings, checked against a local predictor
// or, for typed rows, their own command. Depends on ggdc_pkg and the controller RTL.
`default_nettype none

module go_to_goal_drive_controller_top_tb;
    import ggdc_pkg::*;

    localparam int  DRAIN_CYCLES = 64;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  ROW_COUNT    = 21;
    localparam int  PHASE_ITEMS  = 240;
    localparam longint PI_Q16_TB = 205887;
    localparam longint ARCTAN_Q16 [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };
    // An index past the register list; writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0] lin;
        logic [TURN_W-1:0]  turn;
    } drive_cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [HEAD_W-1:0] hd;
        logic                     typed;
        drive_cmd_t               cmd;
    } pose_row_t;

    // Rows marked typed carry an expectation that is obvious from the
    // reset goal (-1.0, 1.0), gain 1.0 and limit 3.0.
    localparam pose_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{-16'sd256,   16'sd256,    15'sd0,      1'b1, '{15'd0,   15'd0}},
        '{-16'sd231,   16'sd256,    15'sd16383,  1'b1, '{15'd0,   15'd0}},
        '{-16'sd276,   16'sd240,    15'sd0,      1'b0, '{15'd0,   15'd0}},
        '{-16'sd281,   16'sd251,   -15'sd16384,  1'b1, '{15'd0,   15'd0}},
        '{-16'sd768,   16'sd256,    15'sd0,      1'b1, '{15'd512, 15'd0}},
        '{-16'sd2304,  16'sd256,    15'sd0,      1'b1, '{15'd768, 15'd0}},
        '{-16'sd768,   16'sd256,    15'sd16383,  1'b0, '{15'd0,   15'd0}},
        '{-16'sd768,   16'sd256,   -15'sd16384,  1'b0, '{15'd0,   15'd0}},
        '{16'sd32767,  16'sd32767,  15'sd0,      1'b0, '{15'd0,   15'd0}},
        '{16'sd32767, -16'sd32768,  15'sd0,      1'b0, '{15'd0,   15'd0}},
        '{-16'sd32768,-16'sd32768,  15'sd16383,  1'b0, '{15'd0,   15'd0}},
        '{-16'sd32768, 16'sd32767, -15'sd16384,  1'b0, '{15'd0,   15'd0}},
        '{-16'sd256,   16'sd32767,  15'sd0,      1'b0, '{15'd0,   15'd0}},
        '{-16'sd256,  -16'sd32768,  15'sd6434,   1'b0, '{15'd0,   15'd0}},
        '{16'sd256,    16'sd256,    15'sd12868,  1'b0, '{15'd0,   15'd0}},
        '{16'sd256,    16'sd257,   -15'sd12868,  1'b0, '{15'd0,   15'd0}},
        '{-16'sd768,   16'sd256,    15'sd819,    1'b0, '{15'd0,   15'd0}},
        '{-16'sd768,   16'sd256,   -15'sd820,    1'b0, '{15'd0,   15'd0}},
        '{-16'sd256,  -16'sd256,    15'sd6434,   1'b0, '{15'd0,   15'd0}},
        '{16'sh5555,   16'shAAAA,   15'sh2AAA,   1'b0, '{15'd0,   15'd0}},
        '{16'shAAAA,   16'sh5555,   15'sh5555,   1'b0, '{15'd0,   15'd0}}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;
    logic                     out_valid;
    logic                     out_stall;
    logic [SPEED_W-1:0]       linear_speed;
    logic [TURN_W-1:0]        turn_rate;

    // Local copy of the controller registers.
    logic signed [POS_W-1:0] goal_x_q;
    logic signed [POS_W-1:0] goal_y_q;
    logic [GAIN_W-1:0]       gain_q;
    logic [SPEED_W-1:0]      limit_q;

    drive_cmd_t pending_cmds [$];
    int         mismatch_count;
    bit         tx_idle;
    bit         rx_idle;
    bit         hold_req;

    go_to_goal_drive_controller_top #(
        .CORDIC_STAGES(CORDIC_STAGES_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bearing of the offset in Q3.12, by CORDIC vectoring with floor shifts.
    function automatic longint bearing_q12(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q16_TB : -PI_Q16_TB;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q16[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q16[i];
            end
        end
        return (z + 8) >>> 4;
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint root;
        longint t;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = root | (64'sd1 << b);
            if (t * t <= n)
                root = t;
        end
        return root;
    endfunction

    function automatic drive_cmd_t drive_command(input logic signed [POS_W-1:0] px,
                                                 input logic signed [POS_W-1:0] py,
                                                 input logic signed [HEAD_W-1:0] hd);
        longint dx;
        longint dy;
        longint d2;
        longint err;
        longint lin;
        longint turn;
        drive_cmd_t cmd;
        dx = longint'(goal_x_q) - longint'(px);
        dy = longint'(goal_y_q) - longint'(py);
        d2 = dx * dx + dy * dy;
        lin = 0;
        turn = 0;
        if (d2 > 655)
        begin
            err = bearing_q12(dx, dy) - longint'(hd);
            if (err < 0)
                err = -err;
            if (err > 819)
                turn = err;
            else
                lin = (longint'(gain_q) * floor_sqrt(d2)) >>> 8;
        end
        if (lin > longint'(limit_q))
            lin = longint'(limit_q);
        cmd.lin = SPEED_W'(lin);
        cmd.turn = TURN_W'(turn);
        return cmd;
    endfunction

    task automatic offer_pose(input logic signed [POS_W-1:0] px,
                              input logic signed [POS_W-1:0] py,
                              input logic signed [HEAD_W-1:0] hd,
                              input logic typed, input drive_cmd_t typed_cmd);
        if (tx_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        heading <= hd;
        do
            @(posedge clk);
        while (in_stall);
        pending_cmds.push_back(typed ? typed_cmd : drive_command(px, py, hd));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_GOAL_X:      goal_x_q = value;
            REG_GOAL_Y:      goal_y_q = value;
            REG_SPEED_GAIN:  gain_q = value[GAIN_W-1:0];
            REG_SPEED_LIMIT: limit_q = value[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] gx, input logic [CFG_W-1:0] gy,
                                 input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] limit);
        write_reg(REG_NONE, CFG_W'($urandom));
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_SPEED_GAIN, gain);
        write_reg(REG_SPEED_LIMIT, limit);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_pose(output logic signed [POS_W-1:0] px,
                               output logic signed [POS_W-1:0] py,
                               output logic signed [HEAD_W-1:0] hd);
        int kind;
        int span;
        int dxo;
        int dyo;
        int delta;
        longint brg;
        kind = $urandom_range(0, 99);
        px = POS_W'($urandom);
        py = POS_W'($urandom);
        hd = HEAD_W'($urandom);
        if (kind >= 35)
        begin
            // Poses near the goal probe the at-goal boundary; the rest are
            // aimed close to the bearing so that both decisions are exercised.
            span = (kind < 50) ? 32 : (1 << $urandom_range(4, 15));
            dxo = int'($urandom_range(0, 2 * span)) - span;
            dyo = int'($urandom_range(0, 2 * span)) - span;
            px = POS_W'(int'(goal_x_q) - dxo);
            py = POS_W'(int'(goal_y_q) - dyo);
            brg = bearing_q12(longint'(goal_x_q) - longint'(px),
                              longint'(goal_y_q) - longint'(py));
            if (kind >= 75)
            begin
                delta = 817 + int'($urandom_range(0, 5));
                if ($urandom_range(0, 1) == 1)
                    delta = -delta;
                hd = HEAD_W'(brg + delta);
            end
            else if (kind >= 50)
                hd = HEAD_W'(brg + int'($urandom_range(0, 1600)) - 800);
        end
    endtask

    task automatic run_random(input int count, input bit allow_idle, input bit long_hold);
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [HEAD_W-1:0] hd;
        for (int i = 0; i < count; i++)
        begin
            tx_idle = allow_idle && ((i / 40) % 3 != 1);
            rx_idle = allow_idle && ((i / 40) % 3 != 2);
            if (long_hold && i == 60)
                hold_req = 1'b1;
            random_pose(px, py, hd);
            offer_pose(px, py, hd, 1'b0, '0);
        end
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    // while requests keep arriving, so that the pipeline fills up.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        drive_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: linear_speed %0d turn_rate %0d",
                             linear_speed, turn_rate);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (want.lin !== linear_speed || want.turn !== turn_rate)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: linear_speed exp %0d got %0d, turn_rate exp %0d got %0d",
                                 want.lin, linear_speed, want.turn, turn_rate);
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        heading = '0;
        goal_x_q = -16'sd256;
        goal_y_q = 16'sd256;
        gain_q = 12'd256;
        limit_q = 15'd768;
        mismatch_count = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROW_COUNT; r++)
            offer_pose(DIRECTED_ROWS[r].px, DIRECTED_ROWS[r].py, DIRECTED_ROWS[r].hd,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].cmd);
        run_random(PHASE_ITEMS, 1'b1, 1'b1);
        wait_drained();

        apply_setting(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        run_random(PHASE_ITEMS, 1'b1, 1'b0);
        wait_drained();

        apply_setting(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        run_random(PHASE_ITEMS, 1'b1, 1'b0);
        wait_drained();

        apply_setting(16'h8000, 16'h7FFF, 16'h0FFF, CFG_W'($urandom_range(0, 4096)));
        run_random(PHASE_ITEMS, 1'b1, 1'b0);
        wait_drained();

        apply_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                      CFG_W'($urandom));
        run_random(PHASE_ITEMS, 1'b1, 1'b0);
        wait_drained();

        // The last stretch runs with neither side idling.
        apply_setting(CFG_W'($urandom_range(0, 2048)), CFG_W'($urandom_range(0, 2048)),
                      CFG_W'($urandom_range(128, 1024)), CFG_W'($urandom_range(256, 8192)));
        run_random(PHASE_ITEMS, 1'b0, 1'b0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_cmds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
